FILE: hw/rtl/rhw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the divider step function for the RGB to HSV
// white mask core. No dependencies.
package rhw_pkg;

  localparam int unsigned CHAN_W          = 8;
  localparam int unsigned DIV_STAGES      = 6;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned QUO_W           = DIV_STAGES * STEPS_PER_STAGE;
  localparam int unsigned NUM_W           = QUO_W + CHAN_W;
  localparam int unsigned HUE_W           = 15;
  localparam int unsigned SAT_W           = 9;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 9;

  localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;

  localparam logic [CHAN_W-1:0] VALUE_THR_RESET = 8'd153;
  localparam logic [SAT_W-1:0]  SAT_THR_RESET   = 9'd51;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE_THR = 2'd0,
    REG_SAT_THR   = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  saturation;
    logic [CHAN_W-1:0] brightness;
    logic              is_white;
  } result_t;

  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
  } div_lane_t;

  typedef struct packed {
    sector_e           sector;
    logic              neg;
    logic              zero;
    logic [CHAN_W-1:0] bright;
    logic              white;
  } side_t;

  // Two restoring division steps on one lane.
  function automatic div_lane_t div_pair(div_lane_t lane, logic [CHAN_W-1:0] den);
    div_lane_t     res;
    logic [CHAN_W:0] t;
    res = lane;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      t = {res.rem, res.low[QUO_W-1]};
      res.low = {res.low[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        res.rem = CHAN_W'(t - {1'b0, den});
        res.quo = {res.quo[QUO_W-2:0], 1'b1};
      end else begin
        res.rem = t[CHAN_W-1:0];
        res.quo = {res.quo[QUO_W-2:0], 1'b0};
      end
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/rhw_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider pair for hue and saturation, two quotient bits
// per stage, with sideband carried alongside. Depends on rhw_pkg.
module rhw_div_pipe import rhw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  div_lane_t         hue_i,
  input  logic [CHAN_W-1:0] hue_den_i,
  input  div_lane_t         sat_i,
  input  logic [CHAN_W-1:0] sat_den_i,
  input  side_t             side_i,
  output logic              valid_o,
  output div_lane_t         hue_o,
  output div_lane_t         sat_o,
  output side_t             side_o
);

  logic              valid_q   [DIV_STAGES];
  div_lane_t         hue_q     [DIV_STAGES];
  div_lane_t         sat_q     [DIV_STAGES];
  logic [CHAN_W-1:0] hue_den_q [DIV_STAGES];
  logic [CHAN_W-1:0] sat_den_q [DIV_STAGES];
  side_t             side_q    [DIV_STAGES];

  logic              valid_in  [DIV_STAGES];
  div_lane_t         hue_in    [DIV_STAGES];
  div_lane_t         sat_in    [DIV_STAGES];
  logic [CHAN_W-1:0] hue_den_in[DIV_STAGES];
  logic [CHAN_W-1:0] sat_den_in[DIV_STAGES];
  side_t             side_in   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign valid_in[s]   = valid_i;
      assign hue_in[s]     = hue_i;
      assign sat_in[s]     = sat_i;
      assign hue_den_in[s] = hue_den_i;
      assign sat_den_in[s] = sat_den_i;
      assign side_in[s]    = side_i;
    end else begin : g_rest
      assign valid_in[s]   = valid_q[s-1];
      assign hue_in[s]     = hue_q[s-1];
      assign sat_in[s]     = sat_q[s-1];
      assign hue_den_in[s] = hue_den_q[s-1];
      assign sat_den_in[s] = sat_den_q[s-1];
      assign side_in[s]    = side_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      hue_q[s]     <= div_pair(hue_in[s], hue_den_in[s]);
      sat_q[s]     <= div_pair(sat_in[s], sat_den_in[s]);
      hue_den_q[s] <= hue_den_in[s];
      sat_den_q[s] <= sat_den_in[s];
      side_q[s]    <= side_in[s];
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign hue_o   = hue_q[DIV_STAGES-1];
  assign sat_o   = sat_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule

FILE: hw/rtl/rgb_to_hsv_white_mask_core.sv
`timescale 1ns / 1ps
// Top level of the RGB to HSV converter with white pixel flag.
// Depends on rhw_pkg and rhw_div_pipe.
//
// A pixel beat is taken at a rising edge where start is high and busy is low.
// Busy is always low, so one pixel can enter on every clock.
// Each result beat is shown on res_o for exactly one cycle with done_o high.
// Results leave in the order pixels entered, one per cycle at most.
// The path is three front stages (input, max and sector, dividend and white
// test), six divider stages of two quotient bits each, and an output register.
// The receiver cannot stall, so nothing upstream ever waits on it.
// The configuration channel takes a register index and data whenever
// cfg_valid_i is high; cfg_ready_o is always high. Index 0 is the value
// threshold and index 1 the saturation threshold; other indexes are ignored.
// Write it only while no pixel is in flight.
// Reset clears all stage valid bits, so no result appears until a pixel enters,
// and loads the thresholds with 153 and 51.
module rgb_to_hsv_white_mask_core import rhw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pixel_t                pix_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output result_t               res_o
);

  localparam int unsigned LATENCY = DIV_STAGES + 4;

  logic              accept;
  logic [CHAN_W-1:0] value_thr_q;
  logic [SAT_W-1:0]  sat_thr_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_thr_q <= VALUE_THR_RESET;
      sat_thr_q   <= SAT_THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_VALUE_THR: value_thr_q <= cfg_data_i[CHAN_W-1:0];
        REG_SAT_THR:   sat_thr_q   <= cfg_data_i[SAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: input register.
  logic   s1_valid_q;
  pixel_t s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pix_i;
    end
  end

  // Stage 2: max, min, sector and hue numerator magnitude.
  logic [CHAN_W-1:0] s2_max_d, s2_min_d, s2_abs_d;
  logic signed [CHAN_W:0] s2_num_d;
  sector_e           s2_sector_d;

  logic              s2_valid_q;
  logic [CHAN_W-1:0] s2_max_q, s2_spread_q, s2_abs_q;
  logic              s2_neg_q;
  sector_e           s2_sector_q;

  always_comb begin
    s2_max_d = (s1_pix_q.red > s1_pix_q.green) ? s1_pix_q.red : s1_pix_q.green;
    s2_max_d = (s2_max_d > s1_pix_q.blue) ? s2_max_d : s1_pix_q.blue;
    s2_min_d = (s1_pix_q.red < s1_pix_q.green) ? s1_pix_q.red : s1_pix_q.green;
    s2_min_d = (s2_min_d < s1_pix_q.blue) ? s2_min_d : s1_pix_q.blue;
    if (s2_max_d == s1_pix_q.red) begin
      s2_sector_d = SEC_RED;
      s2_num_d    = $signed({1'b0, s1_pix_q.green}) - $signed({1'b0, s1_pix_q.blue});
    end else if (s2_max_d == s1_pix_q.green) begin
      s2_sector_d = SEC_GREEN;
      s2_num_d    = $signed({1'b0, s1_pix_q.blue}) - $signed({1'b0, s1_pix_q.red});
    end else begin
      s2_sector_d = SEC_BLUE;
      s2_num_d    = $signed({1'b0, s1_pix_q.red}) - $signed({1'b0, s1_pix_q.green});
    end
    s2_abs_d = s2_num_d[CHAN_W] ? CHAN_W'(-s2_num_d) : s2_num_d[CHAN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_max_q    <= s2_max_d;
    s2_spread_q <= s2_max_d - s2_min_d;
    s2_abs_q    <= s2_abs_d;
    s2_neg_q    <= s2_num_d[CHAN_W];
    s2_sector_q <= s2_sector_d;
  end

  // Stage 3: dividends and the white test.
  logic [NUM_W-1:0]    s3_hue_num_d, s3_sat_num_d;
  logic [CHAN_W+SAT_W-1:0] s3_sat_prod_d;
  logic                s3_white_d;

  logic              s3_valid_q;
  div_lane_t         s3_hue_q, s3_sat_q;
  logic [CHAN_W-1:0] s3_hue_den_q, s3_sat_den_q;
  side_t             s3_side_q;

  always_comb begin
    s3_hue_num_d  = ({{QUO_W{1'b0}}, s2_abs_q} << 12) - ({{QUO_W{1'b0}}, s2_abs_q} << 8);
    s3_sat_num_d  = NUM_W'({s2_spread_q, 8'h00});
    s3_sat_prod_d = sat_thr_q * s2_max_q;
    s3_white_d    = (s2_max_q > value_thr_q) &&
                    ((CHAN_W+SAT_W)'({s2_spread_q, 8'h00}) < s3_sat_prod_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_hue_q.rem     <= s3_hue_num_d[NUM_W-1:QUO_W];
    s3_hue_q.low     <= s3_hue_num_d[QUO_W-1:0];
    s3_hue_q.quo     <= '0;
    s3_sat_q.rem     <= s3_sat_num_d[NUM_W-1:QUO_W];
    s3_sat_q.low     <= s3_sat_num_d[QUO_W-1:0];
    s3_sat_q.quo     <= '0;
    s3_hue_den_q     <= s2_spread_q;
    s3_sat_den_q     <= s2_max_q;
    s3_side_q.sector <= s2_sector_q;
    s3_side_q.neg    <= s2_neg_q;
    s3_side_q.zero   <= (s2_spread_q == '0);
    s3_side_q.bright <= s2_max_q;
    s3_side_q.white  <= s3_white_d;
  end

  // Divider stages.
  logic      dv_valid;
  div_lane_t dv_hue, dv_sat;
  side_t     dv_side;

  rhw_div_pipe u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s3_valid_q),
    .hue_i     (s3_hue_q),
    .hue_den_i (s3_hue_den_q),
    .sat_i     (s3_sat_q),
    .sat_den_i (s3_sat_den_q),
    .side_i    (s3_side_q),
    .valid_o   (dv_valid),
    .hue_o     (dv_hue),
    .sat_o     (dv_sat),
    .side_o    (dv_side)
  );

  // Output stage: floor correction, sector offset and zero spread.
  logic [QUO_W:0]   qv_d;
  logic [HUE_W-1:0] off_d, hue_d;
  logic             done_q;
  result_t          res_q;

  always_comb begin
    qv_d = {1'b0, dv_hue.quo} + {{QUO_W{1'b0}}, (dv_hue.rem != '0)};
    case (dv_side.sector)
      SEC_RED:   off_d = dv_side.neg ? HUE_FULL : '0;
      SEC_GREEN: off_d = HUE_GREEN;
      SEC_BLUE:  off_d = HUE_BLUE;
      default:   off_d = '0;
    endcase
    if (dv_side.neg) begin
      hue_d = off_d - HUE_W'(qv_d);
    end else begin
      hue_d = off_d + HUE_W'(dv_hue.quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.hue        <= dv_side.zero ? '0 : hue_d;
    res_q.saturation <= dv_side.zero ? '0 : dv_sat.quo[SAT_W-1:0];
    res_q.brightness <= dv_side.bright;
    res_q.is_white   <= dv_side.white;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result beat without a matching start beat");

  a_white_is_bright: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.is_white) |-> (res_o.brightness > value_thr_q))
    else $error("white flag on a pixel not above the value threshold");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.hue < HUE_FULL && res_o.saturation <= 9'd256))
    else $error("hue or saturation out of range");

  a_black_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.brightness == '0) |-> (res_o.saturation == '0 && !res_o.is_white))
    else $error("black pixel with saturation or white flag");

endmodule

FILE: sim/tb_rgb_to_hsv_white_mask_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_hsv_white_mask_core: drives pixel beats in random bursts,
// predicts hue, saturation, value and the white flag, and checks every result beat in order.
// Depends on rhw_pkg and the core RTL.
module tb_rgb_to_hsv_white_mask_core;
  import rhw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned PHASE_PIXELS = 240;
  localparam int unsigned NUM_PHASES   = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  pixel_t                pix_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  done_o;
  result_t               res_o;

  pixel_t  pixel_q[$];
  result_t hsv_expect_q[$];

  logic [CHAN_W-1:0] value_thr;
  logic [SAT_W-1:0]  sat_thr;
  logic              pix_taken;
  logic              cfg_seen;
  int                burst_left;
  int                gap_left;
  int                error_count;
  result_t           exp_res;

  rgb_to_hsv_white_mask_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pix_i      (pix_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic result_t compute_hsv(pixel_t p, logic [CHAN_W-1:0] vthr,
                                          logic [SAT_W-1:0] sthr);
    result_t res;
    int r, g, b, mx, mn, spread, num, prod, q, h;
    r = int'(p.red);
    g = int'(p.green);
    b = int'(p.blue);
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    spread = mx - mn;
    res = '0;
    if (spread != 0) begin
      res.saturation = SAT_W'((spread * 256) / mx);
      if (mx == r) num = g - b;
      else if (mx == g) num = b - r;
      else num = r - g;
      prod = num * 3840;
      q = prod / spread;
      if ((prod % spread) != 0 && prod < 0) q = q - 1;
      if (mx == r) begin
        h = q;
        if (h < 0) h = h + int'(HUE_FULL);
      end else if (mx == g) begin
        h = q + int'(HUE_GREEN);
      end else begin
        h = q + int'(HUE_BLUE);
      end
      res.hue = HUE_W'(h);
    end
    res.brightness = CHAN_W'(mx);
    res.is_white = (mx > int'(vthr)) && (spread * 256 < int'(sthr) * mx);
    return res;
  endfunction

  // Pixel driver: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
      pix_i <= '0;
    end else if (!start || pix_taken) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        pix_i <= pixel_q.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: tracks the thresholds, predicts on each pixel beat, checks each result beat.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_taken <= 1'b0;
      cfg_seen  <= 1'b0;
      value_thr = VALUE_THR_RESET;
      sat_thr   = SAT_THR_RESET;
    end else begin
      pix_taken <= start && !busy;
      cfg_seen  <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_VALUE_THR: value_thr = cfg_data_i[CHAN_W-1:0];
          REG_SAT_THR:   sat_thr = cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) begin
        hsv_expect_q.insert(hsv_expect_q.size(), compute_hsv(pix_i, value_thr, sat_thr));
      end
      if (done_o) begin
        if (hsv_expect_q.size() == 0) begin
          $display("%0t: unexpected result beat hue=%0d sat=%0d val=%0d white=%0b", $time,
                   res_o.hue, res_o.saturation, res_o.brightness, res_o.is_white);
          error_count = error_count + 1;
        end else begin
          exp_res = hsv_expect_q.pop_front();
          if (res_o !== exp_res) begin
            $display("%0t: mismatch expected hue=%0d sat=%0d val=%0d white=%0b", $time,
                     exp_res.hue, exp_res.saturation, exp_res.brightness, exp_res.is_white);
            $display("%0t:          actual   hue=%0d sat=%0d val=%0d white=%0b", $time,
                     res_o.hue, res_o.saturation, res_o.brightness, res_o.is_white);
            error_count = error_count + 1;
          end
        end
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_seen);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_pixel(input int r, input int g, input int b);
    pixel_q.insert(pixel_q.size(),
                   pixel_t'{red: CHAN_W'(r), green: CHAN_W'(g), blue: CHAN_W'(b)});
  endtask

  task automatic drain;
    while (pixel_q.size() != 0 || start || hsv_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count);
    int kind, d, mx;
    for (int unsigned n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          mx = $urandom_range(0, 255);
          push_pixel(mx, mx, mx);
        end
        1: begin
          mx = $urandom_range(0, 255);
          push_pixel(mx, mx, $urandom_range(0, 255));
        end
        2: begin
          mx = $urandom_range(0, 255);
          push_pixel($urandom_range(0, 255), mx, mx);
        end
        3: begin
          mx = $urandom_range(0, 255);
          push_pixel(mx, $urandom_range(0, 255), mx);
        end
        4, 5: begin
          mx = $urandom_range(128, 255);
          d = $urandom_range(0, 64);
          push_pixel(mx - $urandom_range(0, d), mx - $urandom_range(0, d),
                     mx - $urandom_range(0, d));
        end
        default: push_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255));
      endcase
    end
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    pix_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    burst_left  = 0;
    gap_left    = 0;
    error_count = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_pixel(0, 0, 0);
    push_pixel(255, 255, 255);
    push_pixel(1, 1, 1);
    push_pixel(153, 153, 153);
    push_pixel(154, 154, 154);
    push_pixel(255, 0, 0);
    push_pixel(0, 255, 0);
    push_pixel(0, 0, 255);
    push_pixel(255, 255, 0);
    push_pixel(0, 255, 255);
    push_pixel(255, 0, 255);
    push_pixel(255, 0, 1);
    push_pixel(1, 0, 0);
    push_pixel(0, 0, 1);
    push_pixel(10, 200, 90);
    push_pixel(90, 10, 200);
    push_pixel(255, 254, 254);
    push_pixel(200, 161, 161);
    push_pixel(200, 160, 160);
    push_pixel(170, 85, 0);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_VALUE_THR, 9'd0);
          cfg_write(REG_SAT_THR, 9'd0);
        end
        1: begin
          cfg_write(REG_VALUE_THR, 9'd255);
          cfg_write(REG_SAT_THR, 9'd256);
        end
        2: begin
          cfg_write(REG_VALUE_THR, 9'h100);
          cfg_write(REG_SAT_THR, 9'd511);
          cfg_write(REG_SPARE_A, 9'd0);
          cfg_write(REG_SPARE_B, 9'd511);
        end
        3: begin
          cfg_write(REG_VALUE_THR, {1'b1, VALUE_THR_RESET});
          cfg_write(REG_SAT_THR, SAT_THR_RESET);
        end
        default: begin
          cfg_write(REG_VALUE_THR, CFG_DATA_W'($urandom_range(0, 511)));
          cfg_write(REG_SAT_THR, ($urandom_range(0, 3) == 0)
                                 ? CFG_DATA_W'($urandom_range(0, 511))
                                 : CFG_DATA_W'($urandom_range(0, 256)));
          cfg_write(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                    CFG_DATA_W'($urandom_range(0, 511)));
        end
      endcase
      run_random(PHASE_PIXELS);
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0 && hsv_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rhw_pkg.sv
hw/rtl/rhw_div_pipe.sv
hw/rtl/rgb_to_hsv_white_mask_core.sv
sim/tb_rgb_to_hsv_white_mask_core.sv
